// File: sv/pfe_pkg.sv
// pfe_pkg: shared types and constants of the postfix evaluator
// token and status codes, field widths, serial alu request
// no dependencies
`default_nettype none

package pfe_pkg;

    localparam int FUNC_W   = 3;
    localparam int DIGIT_W  = 4;
    localparam int TOP_W    = 32;
    localparam int DEPTH_W  = 5;
    localparam int STATUS_W = 2;

    typedef logic [FUNC_W-1:0] t_func;

    localparam t_func FN_PUSH = 3'd0;
    localparam t_func FN_ADD  = 3'd1;
    localparam t_func FN_SUB  = 3'd2;
    localparam t_func FN_MUL  = 3'd3;
    localparam t_func FN_DIV  = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2,
        ALU_DIV = 2'd3
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

endpackage

`default_nettype wire

// File: sv/pfe_tok_if.sv
// pfe_tok_if: token channel of the postfix evaluator (valid/ready)
// depends on pfe_pkg
`default_nettype none

interface pfe_tok_if import pfe_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [DIGIT_W-1:0] digit;
    logic               new_expression;

    modport source (output valid, output func, output digit, output new_expression,
                    input ready);
    modport sink   (input valid, input func, input digit, input new_expression,
                    output ready);

endinterface

`default_nettype wire

// File: sv/pfe_res_if.sv
// pfe_res_if: result channel of the postfix evaluator (valid/ready)
// depends on pfe_pkg
`default_nettype none

interface pfe_res_if import pfe_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [TOP_W-1:0]    top_value;
    logic [DEPTH_W-1:0]  depth;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output top_value, output depth, output status,
                    input ready);
    modport sink   (input valid, input top_value, input depth, input status,
                    output ready);

endinterface

`default_nettype wire

// File: sv/pfe_ram.sv
// pfe_ram: generic single write port, single read port ram, registered read
// no dependencies
`default_nettype none

module pfe_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: sv/pfe_alu.sv
// pfe_alu: bit-serial add/sub, shift-add multiply and restoring divide
// one operand bit per cycle; depends on pfe_pkg
`default_nettype none

module pfe_alu import pfe_pkg::*; #(
    parameter int  W  = 32,
    localparam int CW = $clog2(W)
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_alu_req     i_req,
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    output logic              o_done,
    output logic [W-1:0]      o_result
);

    typedef enum logic [1:0] {
        A_IDLE,
        A_RUN,
        A_FIX
    } t_astate;

    localparam logic [CW-1:0] LAST = CW'(W - 1);

    t_astate       r_state;
    logic          r_done;
    t_alu_op       r_op;
    logic [W-1:0]  r_a;
    logic [W-1:0]  r_b;
    logic [W-1:0]  r_acc;
    logic [CW-1:0] r_cnt;
    logic          r_carry;
    logic          r_neg;

    logic          w_bb;
    logic          w_sbit;
    logic          w_scarry;
    logic [W-1:0]  w_mul_sum;
    logic [W:0]    w_trial;
    logic [W:0]    w_diff;
    logic          w_qbit;
    logic [W-1:0]  w_mag_a;
    logic [W-1:0]  w_mag_b;
    logic [W-1:0]  w_q_fix;

    always_comb begin
        // subtract as a + ~b + 1, carry preset at start
        w_bb      = r_b[0] ^ (r_op == ALU_SUB);
        w_sbit    = r_a[0] ^ w_bb ^ r_carry;
        w_scarry  = (r_a[0] & w_bb) | (r_carry & (r_a[0] ^ w_bb));
        w_mul_sum = r_acc + r_a;
        w_trial   = {r_acc, r_a[W-1]};
        w_diff    = w_trial - {1'b0, r_b};
        w_qbit    = ~w_diff[W];
        w_mag_a   = i_a[W-1] ? (~i_a + W'(1)) : i_a;
        w_mag_b   = i_b[W-1] ? (~i_b + W'(1)) : i_b;
        w_q_fix   = r_neg ? (~r_a + W'(1)) : r_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                A_IDLE: begin
                    r_done <= 1'b0;
                    if (i_req.start) begin
                        r_state <= A_RUN;
                    end
                end
                A_RUN: begin
                    if (r_cnt == LAST) begin
                        r_state <= A_FIX;
                    end
                end
                A_FIX: begin
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                default: begin
                    r_state <= A_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == A_IDLE && i_req.start) begin
            r_op    <= i_req.op;
            r_cnt   <= '0;
            r_acc   <= '0;
            r_carry <= (i_req.op == ALU_SUB);
            if (i_req.op == ALU_DIV) begin
                r_a   <= w_mag_a;
                r_b   <= w_mag_b;
                r_neg <= i_a[W-1] ^ i_b[W-1];
            end else begin
                r_a   <= i_a;
                r_b   <= i_b;
                r_neg <= 1'b0;
            end
        end else if (r_state == A_RUN) begin
            r_cnt <= r_cnt + CW'(1);
            unique case (r_op)
                ALU_ADD, ALU_SUB: begin
                    r_acc   <= {w_sbit, r_acc[W-1:1]};
                    r_carry <= w_scarry;
                    r_a     <= r_a >> 1;
                    r_b     <= r_b >> 1;
                end
                ALU_MUL: begin
                    if (r_b[0]) begin
                        r_acc <= w_mul_sum;
                    end
                    r_a <= r_a << 1;
                    r_b <= r_b >> 1;
                end
                ALU_DIV: begin
                    // remainder in acc, dividend shifts out of a, quotient shifts in
                    r_acc <= w_qbit ? w_diff[W-1:0] : w_trial[W-1:0];
                    r_a   <= {r_a[W-2:0], w_qbit};
                end
                default: begin
                    r_acc <= r_acc;
                end
            endcase
        end else if (r_state == A_FIX) begin
            if (r_op == ALU_DIV) begin
                r_acc <= w_q_fix;
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

`default_nettype wire

// File: sv/postfix_expression_evaluator.sv
// postfix_expression_evaluator: rpn token evaluator on a bounded operand stack
// order: push, unused and rejected tokens load the output register on accept, or the
//   hold register if the output is full; operator tokens first pass read, calc and the alu
// throughput: one push per cycle while the result side drains; an operator holds the
//   input until its item is done; one token in flight, accepted while a result waits
// reset: synchronous active low, empties the stack and the output; ram not cleared
`default_nettype none

module postfix_expression_evaluator import pfe_pkg::*; #(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pfe_tok_if.sink    i_tok,
    pfe_res_if.source  o_res
);

    localparam int W     = VALUE_WIDTH;
    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    localparam logic [CNT_W-1:0] FULL = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] TWO  = CNT_W'(2);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CALC,
        S_HOLD
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic               r_ov;
    logic               n_ov;
    logic [W-1:0]       r_top;
    logic [W-1:0]       n_top;
    t_alu_op            r_op;
    t_alu_op            n_op;

    logic [TOP_W-1:0]   r_o_top;
    logic [DEPTH_W-1:0] r_o_depth;
    t_status            r_o_status;
    logic [TOP_W-1:0]   r_p_top;
    logic [DEPTH_W-1:0] r_p_depth;
    t_status            r_p_status;

    logic               w_acc;
    logic               w_out_free;
    logic [CNT_W-1:0]   w_cnt0;
    logic [CNT_W-1:0]   w_idx_tok;
    logic [CNT_W-1:0]   w_idx_cur;
    logic               w_fin;
    logic [W-1:0]       w_fin_top;
    logic [CNT_W-1:0]   w_fin_cnt;
    t_status            w_fin_status;
    logic [TOP_W-1:0]   w_top_ext;
    logic [TOP_W-1:0]   w_top32;
    logic [DEPTH_W-1:0] w_depth5;
    logic               w_load_fin;
    logic               w_load_hold;

    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [W-1:0]       w_wdata;
    logic               w_re;
    logic [AW-1:0]      w_raddr;
    logic [W-1:0]       w_rdata;

    t_alu_req           w_alu_req;
    logic               w_alu_done;
    logic [W-1:0]       w_alu_res;

    pfe_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_alu_req.start = (r_state == S_READ);
    assign w_alu_req.op    = r_op;

    pfe_alu #(
        .W (W)
    ) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_alu_req),
        .i_a      (w_rdata),
        .i_b      (r_top),
        .o_done   (w_alu_done),
        .o_result (w_alu_res)
    );

    assign i_tok.ready = (r_state == S_IDLE);
    assign w_acc       = i_tok.valid && i_tok.ready;
    assign w_out_free  = !r_ov || o_res.ready;
    assign w_cnt0      = i_tok.new_expression ? '0 : r_cnt;
    // index of the first operand, one below the top
    assign w_idx_tok   = w_cnt0 - TWO;
    assign w_idx_cur   = r_cnt - TWO;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_top        = r_top;
        n_op         = r_op;
        w_fin        = 1'b0;
        w_fin_status = ST_OK;
        w_we         = 1'b0;
        w_waddr      = r_cnt[AW-1:0];
        w_wdata      = w_alu_res;
        w_re         = 1'b0;
        w_raddr      = w_idx_tok[AW-1:0];
        w_load_hold  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_cnt = w_cnt0;
                    priority if (i_tok.func == FN_PUSH) begin
                        w_fin = 1'b1;
                        if (w_cnt0 >= FULL) begin
                            w_fin_status = ST_OVER;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = w_cnt0[AW-1:0];
                            w_wdata = W'(i_tok.digit);
                            n_top   = W'(i_tok.digit);
                            n_cnt   = w_cnt0 + CNT_W'(1);
                        end
                    end else if (i_tok.func == FN_ADD || i_tok.func == FN_SUB ||
                                 i_tok.func == FN_MUL || i_tok.func == FN_DIV) begin
                        if (w_cnt0 < TWO) begin
                            w_fin        = 1'b1;
                            w_fin_status = ST_UNDER;
                        end else if (i_tok.func == FN_DIV && r_top == '0) begin
                            w_fin        = 1'b1;
                            w_fin_status = ST_DIVZ;
                        end else begin
                            w_re    = 1'b1;
                            n_state = S_READ;
                            priority if (i_tok.func == FN_ADD) begin
                                n_op = ALU_ADD;
                            end else if (i_tok.func == FN_SUB) begin
                                n_op = ALU_SUB;
                            end else if (i_tok.func == FN_MUL) begin
                                n_op = ALU_MUL;
                            end else begin
                                n_op = ALU_DIV;
                            end
                        end
                    end else begin
                        // unused token kinds leave the stack alone, apart from a clear by new_expression
                        w_fin = 1'b1;
                    end
                end
            end
            S_READ: begin
                n_state = S_CALC;
            end
            S_CALC: begin
                if (w_alu_done) begin
                    w_we    = 1'b1;
                    w_waddr = w_idx_cur[AW-1:0];
                    w_wdata = w_alu_res;
                    n_top   = w_alu_res;
                    n_cnt   = r_cnt - CNT_W'(1);
                    w_fin   = 1'b1;
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    w_load_hold = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        w_load_fin = w_fin && w_out_free;
        if (w_fin) begin
            n_state = w_out_free ? S_IDLE : S_HOLD;
        end

        if (w_load_fin || w_load_hold) begin
            n_ov = 1'b1;
        end else if (o_res.ready) begin
            n_ov = 1'b0;
        end else begin
            n_ov = r_ov;
        end
    end

    assign w_fin_top = n_top;
    assign w_fin_cnt = n_cnt;

    generate
        if (W >= TOP_W) begin : g_top_trunc
            assign w_top_ext = w_fin_top[TOP_W-1:0];
        end else begin : g_top_sext
            assign w_top_ext = {{(TOP_W - W){w_fin_top[W-1]}}, w_fin_top};
        end
        if (CNT_W >= DEPTH_W) begin : g_depth_trunc
            assign w_depth5 = w_fin_cnt[DEPTH_W-1:0];
        end else begin : g_depth_zext
            assign w_depth5 = {{(DEPTH_W - CNT_W){1'b0}}, w_fin_cnt};
        end
    endgenerate

    // empty stack reads as zero
    assign w_top32 = (w_fin_cnt == '0) ? '0 : w_top_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        r_op  <= n_op;
        if (w_load_fin) begin
            r_o_top    <= w_top32;
            r_o_depth  <= w_depth5;
            r_o_status <= w_fin_status;
        end else if (w_load_hold) begin
            r_o_top    <= r_p_top;
            r_o_depth  <= r_p_depth;
            r_o_status <= r_p_status;
        end
        if (w_fin && !w_out_free) begin
            r_p_top    <= w_top32;
            r_p_depth  <= w_depth5;
            r_p_status <= w_fin_status;
        end
    end

    assign o_res.valid     = r_ov;
    assign o_res.top_value = r_o_top;
    assign o_res.depth     = r_o_depth;
    assign o_res.status    = r_o_status;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL)
        else $error("stack count beyond depth");

    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_alu_done |-> r_state == S_CALC)
        else $error("alu finished outside of calc state");

    a_hold_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_HOLD |-> r_ov)
        else $error("holding a result while the output is empty");

    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC && w_alu_done) |=> r_cnt == $past(r_cnt) - CNT_W'(1))
        else $error("operator did not pop exactly one value");

    a_read_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> r_cnt >= TWO)
        else $error("operand read with fewer than two values");

endmodule

`default_nettype wire

// File: tb/sv/postfix_expression_evaluator_test.sv
// postfix_expression_evaluator_test: self-checking testbench of the postfix evaluator
// drives tokens, predicts top of stack, depth and status per item, checks every result
// depends on pfe_pkg, pfe_tok_if, pfe_res_if and postfix_expression_evaluator
`default_nettype none

module postfix_expression_evaluator_test import pfe_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH  = 16;
    localparam int VALUE_WIDTH  = TOP_W;
    localparam int OP_LATENCY   = VALUE_WIDTH + 4;
    localparam int MAX_DIGIT    = (1 << DIGIT_W) - 1;
    localparam int FUNC_MAX     = (1 << FUNC_W) - 1;
    localparam int RANDOM_ITEMS = 900;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;

    typedef struct packed {
        logic [TOP_W-1:0]   top_value;
        logic [DEPTH_W-1:0] depth;
        t_status            status;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    pfe_tok_if tok_ch ();
    pfe_res_if res_ch ();

    postfix_expression_evaluator #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (tok_ch),
        .o_res   (res_ch)
    );

    // predicted stack state, updated at each accepted token
    t_value      stack_mem [STACK_DEPTH];
    int unsigned stack_count;
    t_result     pending_results [$];
    int          errors;
    bit          calm;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("postfix_expression_evaluator_test NOT OK");
        $finish;
    end

    function automatic t_value divide_trunc(t_value num, t_value den);
        logic signed [63:0] wide_num;
        logic signed [63:0] wide_den;
        logic [63:0]        mag_num;
        logic [63:0]        mag_den;
        logic [63:0]        quot;
        wide_num = num;
        wide_den = den;
        mag_num  = wide_num[63] ? -wide_num : wide_num;
        mag_den  = wide_den[63] ? -wide_den : wide_den;
        quot     = mag_num / mag_den;
        if (wide_num[63] ^ wide_den[63]) begin
            quot = -quot;
        end
        return quot[VALUE_WIDTH-1:0];
    endfunction

    function automatic t_result evaluate_token(t_func func, logic [DIGIT_W-1:0] digit,
                                               logic new_expr);
        t_value  first;
        t_value  second;
        t_value  acc;
        t_status st;
        t_result res;
        st  = ST_OK;
        acc = '0;
        if (new_expr) begin
            stack_count = 0;
        end
        case (func)
            FN_PUSH: begin
                if (stack_count >= STACK_DEPTH) begin
                    st = ST_OVER;
                end else begin
                    stack_mem[stack_count] = VALUE_WIDTH'(digit);
                    stack_count++;
                end
            end
            FN_ADD, FN_SUB, FN_MUL, FN_DIV: begin
                if (stack_count < 2) begin
                    st = ST_UNDER;
                end else begin
                    second = stack_mem[stack_count-1];
                    first  = stack_mem[stack_count-2];
                    case (func)
                        FN_ADD: acc = first + second;
                        FN_SUB: acc = first - second;
                        FN_MUL: acc = first * second;
                        default: begin
                            if (second == 0) st = ST_DIVZ;
                            else acc = divide_trunc(first, second);
                        end
                    endcase
                    if (st == ST_OK) begin
                        stack_count--;
                        stack_mem[stack_count-1] = acc;
                    end
                end
            end
            default: ;
        endcase
        res.top_value = (stack_count > 0) ? stack_mem[stack_count-1] : '0;
        res.depth     = DEPTH_W'(stack_count);
        res.status    = st;
        return res;
    endfunction

    // mostly short gaps, a few long ones, none during a calm stretch
    function automatic int pick_gap();
        int roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_token(t_func func, logic [DIGIT_W-1:0] digit, logic new_expr);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            tok_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        tok_ch.valid          <= 1'b1;
        tok_ch.func           <= func;
        tok_ch.digit          <= digit;
        tok_ch.new_expression <= new_expr;
        @(posedge i_clk);
        while (!tok_ch.ready) @(posedge i_clk);
        pending_results.push_back(evaluate_token(func, digit, new_expr));
    endtask

    task automatic test_stack_limits();
        for (int d = 0; d <= MAX_DIGIT; d++) begin
            send_token(FN_PUSH, DIGIT_W'(d), d == 0);
        end
        // push on a full stack
        send_token(FN_PUSH, 4'd9, 1'b0);
        // operator right after a clear, then with a single value
        send_token(FN_ADD, 4'd0, 1'b1);
        send_token(FN_PUSH, 4'd7, 1'b0);
        send_token(FN_SUB, 4'd0, 1'b0);
    endtask

    task automatic test_division_edges();
        // 0 - 7 checks operand order, -7 / 2 checks truncation toward zero
        send_token(FN_PUSH, 4'd0, 1'b1);
        send_token(FN_PUSH, 4'd7, 1'b0);
        send_token(FN_SUB, 4'd0, 1'b0);
        send_token(FN_PUSH, 4'd2, 1'b0);
        send_token(FN_DIV, 4'd0, 1'b0);
        send_token(FN_PUSH, 4'd0, 1'b0);
        send_token(FN_DIV, 4'd0, 1'b0);
        send_token(FN_MUL, 4'd0, 1'b0);
    endtask

    task automatic test_most_negative_quotient();
        // 8^10 * 2 wraps to the most negative value, then divide by -1
        for (int i = 0; i < 10; i++) begin
            send_token(FN_PUSH, 4'd8, i == 0);
        end
        repeat (9) send_token(FN_MUL, 4'd0, 1'b0);
        send_token(FN_PUSH, 4'd2, 1'b0);
        send_token(FN_MUL, 4'd0, 1'b0);
        send_token(FN_PUSH, 4'd0, 1'b0);
        send_token(FN_PUSH, 4'd1, 1'b0);
        send_token(FN_SUB, 4'd0, 1'b0);
        send_token(FN_DIV, 4'd0, 1'b0);
    endtask

    task automatic test_unused_tokens();
        send_token(FN_PUSH, 4'd5, 1'b1);
        for (int f = FN_DIV + 1; f <= FUNC_MAX; f++) begin
            send_token(t_func'(f), DIGIT_W'($urandom_range(0, MAX_DIGIT)), f == FUNC_MAX);
        end
    endtask

    task automatic test_random_expressions();
        int    n_items;
        int    len;
        int    push_pct;
        bit    noisy;
        t_func func;
        logic  new_expr;
        n_items = 0;
        while (n_items < RANDOM_ITEMS) begin
            calm     = ($urandom_range(0, 7) == 0);
            noisy    = ($urandom_range(0, 9) == 0);
            len      = $urandom_range(2, 30);
            case ($urandom_range(0, 2))
                0: push_pct = 30;
                1: push_pct = 50;
                default: push_pct = 80;
            endcase
            for (int i = 0; i < len; i++) begin
                new_expr = (i == 0) || ($urandom_range(0, 49) == 0);
                if (noisy) begin
                    func     = t_func'($urandom_range(0, FUNC_MAX));
                    new_expr = $urandom_range(0, 1);
                end else if ($urandom_range(0, 19) == 0) begin
                    // broken step: any push or operator token regardless of depth
                    func = t_func'($urandom_range(FN_PUSH, FN_DIV));
                end else if (new_expr || stack_count < 2) begin
                    func = FN_PUSH;
                end else if (stack_count >= STACK_DEPTH
                             || $urandom_range(0, 99) >= push_pct) begin
                    func = t_func'($urandom_range(FN_ADD, FN_DIV));
                end else begin
                    func = FN_PUSH;
                end
                send_token(func, DIGIT_W'($urandom_range(0, MAX_DIGIT)), new_expr);
                if (func <= FN_DIV) n_items++;
            end
        end
        calm = 1'b0;
    endtask

    // result side stalls
    initial begin
        int hold;
        hold = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                res_ch.ready <= 1'b0;
            end else if (hold > 0) begin
                res_ch.ready <= 1'b0;
                hold--;
            end else begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) hold = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result exp_res;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item top_value %0d depth %0d status %0d", $time,
                         $signed(res_ch.top_value), res_ch.depth, res_ch.status);
                errors++;
            end else begin
                exp_res = pending_results.pop_front();
                if (res_ch.top_value !== exp_res.top_value) begin
                    $display("%0t: top_value expected %0d actual %0d", $time,
                             $signed(exp_res.top_value), $signed(res_ch.top_value));
                    errors++;
                end
                if (res_ch.depth !== exp_res.depth) begin
                    $display("%0t: depth expected %0d actual %0d", $time,
                             exp_res.depth, res_ch.depth);
                    errors++;
                end
                if (res_ch.status !== exp_res.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_res.status, res_ch.status);
                    errors++;
                end
            end
        end
    end

    initial begin
        errors                = 0;
        calm                  = 1'b0;
        stack_count           = 0;
        i_rst_n               = 1'b0;
        tok_ch.valid          = 1'b0;
        tok_ch.func           = FN_PUSH;
        tok_ch.digit          = '0;
        tok_ch.new_expression = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_stack_limits();
        test_division_edges();
        test_most_negative_quotient();
        test_unused_tokens();
        test_random_expressions();

        @(negedge i_clk);
        tok_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (OP_LATENCY + 10) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("postfix_expression_evaluator_test OK");
        end else begin
            $display("postfix_expression_evaluator_test NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
sv/pfe_pkg.sv
sv/pfe_tok_if.sv
sv/pfe_res_if.sv
sv/pfe_ram.sv
sv/pfe_alu.sv
sv/postfix_expression_evaluator.sv
tb/sv/postfix_expression_evaluator_test.sv
